@@ rtl/ipi_pkg.sv @@
// shared constants for the interpolated path increment block
// stream layout, register indexes and fixed field widths; no dependencies
package ipi_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  // stream widths
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEZE       = 3'd4;

  // input beat kinds carried in tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // saturation limits of the 48 bit load increment
  localparam logic [47:0] LOAD_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] LOAD_MIN = 48'h8000_0000_0000;
  localparam logic [65:0] NEG_LIM  = 66'h0_0000_8000_0000_0000;
  localparam logic [65:0] POS_LIM  = 66'h0_0000_7FFF_FFFF_FFFF;

endpackage

@@ rtl/ipi_ram.sv @@
// generic single write, single read port ram with registered read data
// no dependencies
module ipi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/interpolated_path_increment.sv @@
// Piecewise linear path table with penalty load increment, top level.
// Depends on ipi_pkg and ipi_ram (time and value tables).
//
// Input stream: tuser is the beat kind (0 writes a table point, 1 queries).
// A write beat stores time and value at point_index and gives no output.
// A query beat gives one output beat: tdata is the saturated load increment,
// tuser is in_range. Out of range, negative, frozen or empty-table queries
// give zero with in_range low and keep the stored previous load.
// One item is worked at a time; s_axis_tready is high while the control is
// idle, also while an output beat still waits to be taken.
// A write is stored when its beat is accepted. A table-mode query walks the
// cursor one point at a time and, unless the query time equals the cursor's
// point, runs the shared bit-serial divider for the fraction and interpolates;
// it then scales and multiplies by the gain. A uniform-mode query runs the
// divider for the integer part and, unless it lands on the last point, for
// the fraction. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while idle. Reset clears the cursor, the previous load and the registers,
// but sets the scale factor to 1.0; the tables hold nothing until written.
// A stalled receiver holds the output beat and the block waits to present
// the next result until it is taken.
module interpolated_path_increment
  #(
  parameter int TABLE_DEPTH = ipi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [ipi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: point_index[9:0], point_time[41:10], point_value[73:42],
  //        query_time[105:74], zero fill
  input  logic [ipi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: load_increment[47:0]
  output logic [ipi_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: in_range
  output logic                           m_axis_tuser
);
  import ipi_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int N_W   = IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_T_RD, S_T_CHK, S_F_RD, S_F_CHK, S_B_RD, S_B_CHK,
    S_DIV, S_U_CHK, S_U_LO, S_U_HI, S_U_VAL,
    S_LERP_MUL, S_LERP_ADD, S_SCALE, S_DIFF, S_INC_MUL, S_INC_SAT, S_EMIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [31:0] gain_q, sf_q, step_q;
  logic [10:0] pc_q;
  logic        freeze_q;

  // persistent state
  logic [IDX_W-1:0] cursor_q;
  logic [47:0]      prev_q;

  // working registers
  logic [31:0] q_q;
  logic [31:0] t_lo_q, t_hi_q, v_lo_q, v_hi_q, val_q;
  logic [31:0] div_r_q, div_s_q, div_quo_q, div_d_q;
  logic [5:0]  div_cnt_q;
  logic        div_frac_q;
  logic [65:0] prod_q;
  logic [47:0] cur_q;
  logic [48:0] mag_q;
  logic        neg_q;
  logic [64:0] phi_q, plo_q;
  logic [47:0] res_q;
  logic        ok_q;

  // output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_user_q;

  // input fields
  logic [9:0]  in_idx;
  logic [31:0] in_time, in_value, in_query;
  assign in_idx   = s_axis_tdata[9:0];
  assign in_time  = s_axis_tdata[41:10];
  assign in_value = s_axis_tdata[73:42];
  assign in_query = s_axis_tdata[105:74];

  logic s_accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // effective point count and clamped cursor
  logic [N_W-1:0]   n_eff;
  logic [IDX_W-1:0] last_idx, cur_clamp;
  assign n_eff     = (32'(pc_q) > TABLE_DEPTH) ? N_W'(TABLE_DEPTH) : N_W'(pc_q);
  assign last_idx  = IDX_W'(n_eff - N_W'(1));
  assign cur_clamp = (cursor_q > last_idx) ? last_idx : cursor_q;

  // table memories
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [31:0]      rt, rv;
  assign wr_en   = s_accept && (s_axis_tuser == MODE_WRITE) && (32'(in_idx) < TABLE_DEPTH);
  assign wr_addr = IDX_W'(in_idx);

  ipi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(in_time),
    .raddr_i(rd_addr),
    .rdata_o(rt)
  );

  ipi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(in_value),
    .raddr_i(rd_addr),
    .rdata_o(rv)
  );

  // read address per state
  always_comb begin
    unique case (state_q)
      S_F_RD:  rd_addr = cursor_q + IDX_W'(1);
      S_U_CHK: rd_addr = IDX_W'(div_quo_q);
      S_U_LO:  rd_addr = IDX_W'(div_quo_q + 32'd1);
      default: rd_addr = cursor_q;
    endcase
  end

  // divider step: one quotient bit per cycle
  logic [32:0] div_rr;
  logic        div_ge;
  logic [31:0] div_r_next;
  assign div_rr     = {div_r_q, div_s_q[31]};
  assign div_ge     = div_rr >= {1'b0, div_d_q};
  assign div_r_next = div_ge ? 32'(div_rr - {1'b0, div_d_q}) : div_rr[31:0];

  // walk compares
  logic at_last, fwd_more;
  assign at_last  = (N_W'(cursor_q) == N_W'(last_idx));
  assign fwd_more = (N_W'(cursor_q) + N_W'(2)) < n_eff;

  // uniform index checks
  logic u_inside, u_hit;
  assign u_inside = ({1'b0, div_quo_q} + 33'd1) < 33'(n_eff);
  assign u_hit    = (div_quo_q == 32'(last_idx)) && (div_r_q == 32'd0);

  // arithmetic datapath terms
  logic signed [32:0] lerp_d;
  logic signed [65:0] lerp_p;
  logic signed [63:0] scale_p;
  logic signed [48:0] diff;
  logic [65:0]        inc_sum;
  assign lerp_d  = $signed({v_hi_q[31], v_hi_q}) - $signed({v_lo_q[31], v_lo_q});
  assign lerp_p  = lerp_d * $signed({1'b0, div_quo_q});
  assign scale_p = $signed(sf_q) * $signed(val_q);
  assign diff    = $signed({cur_q[47], cur_q}) - $signed({prev_q[47], prev_q});
  assign inc_sum = {1'b0, phi_q} + 66'(plo_q[64:16]);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      gain_q     <= '0;
      sf_q       <= 32'h0001_0000;
      step_q     <= '0;
      pc_q       <= '0;
      freeze_q   <= 1'b0;
      cursor_q   <= '0;
      prev_q     <= '0;
      q_q        <= '0;
      t_lo_q     <= '0;
      t_hi_q     <= '0;
      v_lo_q     <= '0;
      v_hi_q     <= '0;
      val_q      <= '0;
      div_r_q    <= '0;
      div_s_q    <= '0;
      div_quo_q  <= '0;
      div_d_q    <= '0;
      div_cnt_q  <= '0;
      div_frac_q <= 1'b0;
      prod_q     <= '0;
      cur_q      <= '0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      phi_q      <= '0;
      plo_q      <= '0;
      res_q      <= '0;
      ok_q       <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= 1'b0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PENALTY_GAIN: gain_q   <= cfg_data_i;
          CFG_SCALE_FACTOR: sf_q     <= cfg_data_i;
          CFG_UNIFORM_STEP: step_q   <= cfg_data_i;
          CFG_POINT_COUNT:  pc_q     <= cfg_data_i[10:0];
          CFG_FREEZE:       freeze_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // output beat loaded from emit, cleared when taken
      if ((state_q == S_EMIT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_accept && (s_axis_tuser == MODE_QUERY)) begin
            q_q   <= in_query;
            res_q <= '0;
            ok_q  <= 1'b0;
            if (in_query[31] || freeze_q || (n_eff == '0)) begin
              state_q <= S_EMIT;
            end else if (step_q == 32'd0) begin
              cursor_q <= cur_clamp;
              state_q  <= S_T_RD;
            end else begin
              // integer part: q / step
              div_r_q    <= '0;
              div_s_q    <= in_query;
              div_quo_q  <= '0;
              div_d_q    <= step_q;
              div_cnt_q  <= 6'd32;
              div_frac_q <= 1'b0;
              state_q    <= S_DIV;
            end
          end
        end
        S_T_RD: state_q <= S_T_CHK;
        S_T_CHK: begin
          t_lo_q <= rt;
          v_lo_q <= rv;
          if (q_q == rt) begin
            val_q   <= rv;
            state_q <= S_SCALE;
          end else if (q_q > rt) begin
            state_q <= at_last ? S_EMIT : S_F_RD;
          end else if (cursor_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            t_hi_q   <= rt;
            v_hi_q   <= rv;
            cursor_q <= cursor_q - IDX_W'(1);
            state_q  <= S_B_RD;
          end
        end
        S_F_RD: state_q <= S_F_CHK;
        S_F_CHK: begin
          if (q_q > rt && fwd_more) begin
            t_lo_q   <= rt;
            v_lo_q   <= rv;
            cursor_q <= cursor_q + IDX_W'(1);
            state_q  <= S_F_RD;
          end else if (q_q > rt) begin
            state_q <= S_EMIT;
          end else begin
            // bracket found: fraction (q - t_lo) / (t_hi - t_lo)
            t_hi_q     <= rt;
            v_hi_q     <= rv;
            div_s_q    <= '0;
            div_d_q    <= rt - t_lo_q;
            div_cnt_q  <= 6'd31;
            div_frac_q <= 1'b1;
            if ((q_q - t_lo_q) >= (rt - t_lo_q)) begin
              div_r_q   <= (q_q - t_lo_q) - (rt - t_lo_q);
              div_quo_q <= 32'd1;
            end else begin
              div_r_q   <= q_q - t_lo_q;
              div_quo_q <= 32'd0;
            end
            state_q <= S_DIV;
          end
        end
        S_B_RD: state_q <= S_B_CHK;
        S_B_CHK: begin
          if (q_q < rt && cursor_q != '0) begin
            t_hi_q   <= rt;
            v_hi_q   <= rv;
            cursor_q <= cursor_q - IDX_W'(1);
            state_q  <= S_B_RD;
          end else if (q_q < rt) begin
            state_q <= S_EMIT;
          end else begin
            t_lo_q     <= rt;
            v_lo_q     <= rv;
            div_s_q    <= '0;
            div_d_q    <= t_hi_q - rt;
            div_cnt_q  <= 6'd31;
            div_frac_q <= 1'b1;
            if ((q_q - rt) >= (t_hi_q - rt)) begin
              div_r_q   <= (q_q - rt) - (t_hi_q - rt);
              div_quo_q <= 32'd1;
            end else begin
              div_r_q   <= q_q - rt;
              div_quo_q <= 32'd0;
            end
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          div_r_q   <= div_r_next;
          div_s_q   <= {div_s_q[30:0], 1'b0};
          div_quo_q <= {div_quo_q[30:0], div_ge};
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == 6'd1) begin
            state_q <= div_frac_q ? S_LERP_MUL : S_U_CHK;
          end
        end
        S_U_CHK: begin
          if (u_inside) begin
            state_q <= S_U_LO;
          end else if (u_hit) begin
            state_q <= S_U_VAL;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_U_LO: begin
          v_lo_q  <= rv;
          state_q <= S_U_HI;
        end
        S_U_HI: begin
          // fraction rem / step, rem already below step
          v_hi_q     <= rv;
          div_s_q    <= '0;
          div_quo_q  <= '0;
          div_d_q    <= step_q;
          div_cnt_q  <= 6'd31;
          div_frac_q <= 1'b1;
          state_q    <= S_DIV;
        end
        S_U_VAL: begin
          val_q   <= rv;
          state_q <= S_SCALE;
        end
        S_LERP_MUL: begin
          prod_q  <= 66'(lerp_p);
          state_q <= S_LERP_ADD;
        end
        S_LERP_ADD: begin
          val_q   <= v_lo_q + prod_q[62:31];
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          cur_q   <= scale_p[63:16];
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          prev_q  <= cur_q;
          neg_q   <= diff[48];
          mag_q   <= diff[48] ? 49'(-diff) : 49'(diff);
          state_q <= S_INC_MUL;
        end
        S_INC_MUL: begin
          phi_q   <= 65'(mag_q * gain_q[31:16]);
          plo_q   <= 65'(mag_q * gain_q[15:0]);
          state_q <= S_INC_SAT;
        end
        S_INC_SAT: begin
          ok_q <= 1'b1;
          if (neg_q) begin
            res_q <= (inc_sum > NEG_LIM) ? LOAD_MIN : 48'(-inc_sum);
          end else begin
            res_q <= (inc_sum > POS_LIM) ? LOAD_MAX : inc_sum[47:0];
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= res_q;
            m_user_q  <= ok_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ bench/interpolated_path_increment_chk.sv @@
// checker for the interpolated path increment block: watches config, input and output beats
// predicts each query result and compares it; depends on ipi_pkg
module interpolated_path_increment_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [ipi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [ipi_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                           m_axis_tuser,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ipi_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [47:0] load_inc;
    logic        in_range;
  } load_result_t;

  logic [31:0]        pt_time [DEPTH];
  logic signed [31:0] pt_value[DEPTH];
  int unsigned        walk_pos;
  logic signed [47:0] last_load;
  logic [31:0]        gain;
  logic signed [31:0] scale;
  logic [31:0]        step;
  logic [10:0]        count;
  logic               frozen;
  load_result_t       expected_loads[$];
  int                 fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_loads.size();

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // v1 + floor((v2 - v1) * frac / 2^31)
  function automatic logic signed [31:0] blend(input logic signed [31:0] v1,
                                               input logic signed [31:0] v2,
                                               input logic [63:0] frac);
    logic signed [95:0] prod;
    prod = ($signed({{64{v2[31]}}, v2}) - $signed({{64{v1[31]}}, v1})) * $signed({32'd0, frac});
    return 32'(v1 + (prod >>> 31));
  endfunction

  function automatic load_result_t eval_query(input logic signed [31:0] qs);
    int unsigned        n, c;
    logic [31:0]        q, t1, t2;
    logic signed [31:0] val;
    logic [63:0]        k, rem;
    logic signed [79:0] cur, diff;
    logic [79:0]        mag;
    logic [127:0]       res;
    load_result_t       r;
    r = '0;
    n = (count > DEPTH) ? DEPTH : count;
    if (qs < 0 || frozen || n == 0) return r;
    q = qs;
    if (step == 0) begin
      if (walk_pos > n - 1) walk_pos = n - 1;
      c = walk_pos;
      if (q == pt_time[c]) begin
        val = pt_value[c];
      end else begin
        if (q > pt_time[c]) begin
          if (c == n - 1) return r;
          while (q > pt_time[c + 1] && c < n - 2) c++;
          walk_pos = c;
          if (q > pt_time[c + 1]) return r;
        end else begin
          if (c == 0) return r;
          while (q < pt_time[c] && c > 0) c--;
          walk_pos = c;
          if (q < pt_time[c]) return r;
        end
        t1 = pt_time[c];
        t2 = pt_time[c + 1];
        val = blend(pt_value[c], pt_value[c + 1],
                    ({32'd0, q - t1} << 31) / {32'd0, t2 - t1});
      end
    end else begin
      k   = q / step;
      rem = q % step;
      if (k + 1 < n) val = blend(pt_value[k], pt_value[k + 1], (rem << 31) / step);
      else if (k == n - 1 && rem == 0) val = pt_value[k];
      else return r;
    end
    cur  = ($signed({{48{scale[31]}}, scale}) * $signed({{48{val[31]}}, val})) >>> 16;
    diff = cur - $signed({{32{last_load[47]}}, last_load});
    last_load = cur[47:0];
    mag = diff < 0 ? -diff : diff;
    res = mag * gain[31:16] + ((mag * gain[15:0]) >> 16);
    if (diff < 0) r.load_inc = (res > 128'h8000_0000_0000) ? LOAD_MIN : 48'(-res);
    else          r.load_inc = (res > 128'h7FFF_FFFF_FFFF) ? LOAD_MAX : res[47:0];
    r.in_range = 1'b1;
    return r;
  endfunction

  // follow config, input beats and output beats
  always @(posedge clk_i or negedge rst_ni) begin
    load_result_t got, want;
    if (!rst_ni) begin
      walk_pos = 0; last_load = '0; gain = '0; scale = 32'sd65536;
      step = '0; count = '0; frozen = 1'b0; fail_count = 0;
      expected_loads.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PENALTY_GAIN: gain   = cfg_data_i;
          CFG_SCALE_FACTOR: scale  = cfg_data_i;
          CFG_UNIFORM_STEP: step   = cfg_data_i;
          CFG_POINT_COUNT:  count  = cfg_data_i[10:0];
          CFG_FREEZE:       frozen = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_WRITE) begin
          pt_time[s_axis_tdata[9:0]]  = s_axis_tdata[41:10];
          pt_value[s_axis_tdata[9:0]] = s_axis_tdata[73:42];
        end else begin
          expected_loads.push_back(eval_query(s_axis_tdata[105:74]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser};
        if (expected_loads.size() == 0) begin
          report_mismatch($sformatf("unexpected beat inc=%h rng=%b", got.load_inc, got.in_range));
        end else begin
          want = expected_loads.pop_front();
          if (got.load_inc !== want.load_inc)
            report_mismatch($sformatf("load_increment %h, want %h", got.load_inc, want.load_inc));
          if (got.in_range !== want.in_range)
            report_mismatch($sformatf("in_range %b, want %b", got.in_range, want.in_range));
        end
      end
    end
  end

endmodule

@@ bench/interpolated_path_increment_tb.sv @@
// top of the interpolated path increment bench: clock, reset, stimulus and verdict
// depends on ipi_pkg, the block and interpolated_path_increment_chk
module interpolated_path_increment_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipi_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  int                    fail_count, pending;
  int                    idle_pct = 30;
  int                    hold_cycles = 0;
  logic [31:0]           sweep_end; // time of the last point of the loaded path

  interpolated_path_increment DUT (.*);
  interpolated_path_increment_chk u_chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("interpolated_path_increment_tb: done, errors");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // offer one beat; valid stays up for a back to back follower
  task automatic send_beat(input logic mode, input logic [9:0] idx, input logic [31:0] t,
                           input logic [31:0] v, input logic [31:0] q);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, q, v, t, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic query(input logic [31:0] q);
    send_beat(MODE_QUERY, 10'($urandom), $urandom, $urandom, q);
  endtask

  // drain, then give the block time to settle before touching registers
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2200) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ascending path of n points with random gaps and values
  task automatic load_path(input int n, input int max_gap);
    logic [31:0] t;
    t = $urandom_range(3 * 65536);
    for (int i = 0; i < n; i++) begin
      send_beat(MODE_WRITE, 10'(i), t, $urandom, $urandom);
      sweep_end = t;
      t += $urandom_range(max_gap, 1);
    end
  endtask

  initial begin
    int n, kind;
    logic [31:0] q;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: empty table, then corners of the fields
    query(32'h0000_1000);
    send_beat(MODE_WRITE, 10'd0, 32'd0, 32'h7FFF_FFFF, '0);
    send_beat(MODE_WRITE, 10'd1, 32'h0001_0000, 32'h8000_0000, '0);
    send_beat(MODE_WRITE, 10'd2, 32'h7FFF_FFFF, 32'd0, '0);
    send_beat(MODE_WRITE, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    set_reg(CFG_POINT_COUNT, 32'd3);
    set_reg(CFG_PENALTY_GAIN, 32'hFFFF_FFFF);
    query(32'd0); query(32'h0000_8000); query(32'h0001_0000); query(32'h7FFF_FFFF);
    query(32'h8000_0000); query(32'h0000_4000); query(32'd0);
    set_reg(CFG_SCALE_FACTOR, 32'h8000_0000);
    query(32'h0000_C000); query(32'h0001_0000); query(32'h4000_0000);
    set_reg(CFG_FREEZE, 32'd1);
    query(32'h0000_8000);
    set_reg(CFG_FREEZE, 32'd0);
    set_reg(CFG_POINT_COUNT, 32'd2047); // above depth: clamps to full table
    set_reg(CFG_POINT_COUNT, 32'd3);
    set_reg(CFG_UNIFORM_STEP, 32'h0001_0000);
    query(32'h0000_8000); query(32'h0002_0000); query(32'h0002_0001);
    set_reg(CFG_UNIFORM_STEP, 32'hFFFF_FFFF);
    query(32'h7FFF_FFFF);
    set_reg(CFG_UNIFORM_STEP, 32'd0);

    // random phases: load a path, then sweep queries across it
    for (int ph = 0; ph < 10; ph++) begin
      n = (ph == 9) ? 24 : $urandom_range(12, 2);
      idle_pct = (ph == 4) ? 0 : 30;
      set_reg(CFG_POINT_COUNT, n);
      set_reg(CFG_PENALTY_GAIN, (ph % 3 == 0) ? $urandom : $urandom_range(4 * 65536));
      set_reg(CFG_SCALE_FACTOR, (ph % 4 == 1) ? $urandom : $urandom_range(131072) - 65536);
      set_reg(CFG_UNIFORM_STEP, (ph % 2) ? $urandom_range(4 * 65536, 1) : 0);
      set_reg(CFG_FREEZE, 32'(ph == 6));
      load_path(n, 4 * 65536);
      if (ph == 3) hold_cycles = 300; // receiver stalls while queries keep coming
      for (int i = 0; i < ((ph == 9) ? 6 : 40); i++) begin
        kind = $urandom_range(99);
        if (kind < 75) q = $urandom_range(sweep_end + 65536);
        else if (kind < 90) q = $urandom;
        else q = sweep_end;
        query(q);
      end
      set_reg(CFG_FREEZE, 32'd0);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("interpolated_path_increment_tb: done, clean");
    else $display("interpolated_path_increment_tb: done, errors");
    $finish;
  end

endmodule
